// File: src/vrm_pkg.sv
// Shared types and constants for the voxel ray march pick block.
`timescale 1ns / 1ps

package vrm_pkg;

	localparam int COORD_W    = 16;
	localparam int STEP_W     = 8;
	localparam int MAXD_W     = 12;
	localparam int DIST_W     = 13;
	localparam int POS_W      = 32;
	localparam int VOX_W      = 10;
	localparam int DIR_SHIFT  = 14;
	localparam int OUT_W      = 8;
	localparam int VXIN_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;

	localparam logic [STEP_W-1:0] STEP_RESET = 8'd26;
	localparam logic [MAXD_W-1:0] MAXD_RESET = 12'd1280;
	localparam logic [OUT_W-1:0]  COORD_NONE = 8'hFF;

	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_SAMPLE   = 8'b0000_0100,
		ST_CHECK    = 8'b0000_1000,
		ST_HIT      = 8'b0001_0000,
		ST_MISS     = 8'b0010_0000,
		ST_WR_READ  = 8'b0100_0000,
		ST_WR_WRITE = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic advance;
		logic rd_write;
		logic wr_write;
		logic load_hit;
		logic load_miss;
	} cmd_t;

	typedef struct packed {
		logic op_ray;
		logic clr_last;
		logic dist_over;
		logic solid;
		logic wr_in_grid;
		logic out_free;
	} sts_t;

endpackage

// File: src/vrm_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module vrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/vrm_ctrl.sv
// Sequencer for map clearing, voxel writes and the ray march loop.
`timescale 1ns / 1ps

module vrm_ctrl import vrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.op_ray ? ST_SAMPLE : ST_WR_READ;
				end
			end
			ST_SAMPLE: begin
				state_d = sts.dist_over ? ST_MISS : ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.solid) begin
					state_d = ST_HIT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_SAMPLE;
				end
			end
			ST_HIT: begin
				if (sts.out_free) begin
					cmd.load_hit = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_MISS: begin
				if (sts.out_free) begin
					cmd.load_miss = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_WR_READ: begin
				cmd.rd_write = 1'b1;
				state_d      = ST_WR_WRITE;
			end
			ST_WR_WRITE: begin
				cmd.wr_write = sts.wr_in_grid;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: src/vrm_dp.sv
// Datapath: config registers, occupancy row memory, ray stepper, result register.
`timescale 1ns / 1ps

module vrm_dp import vrm_pkg::*; #(
	parameter int GRID_EDGE = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  logic                         cfg_valid,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         operation,
	input  logic [VXIN_W-1:0]            voxel_x,
	input  logic [VXIN_W-1:0]            voxel_y,
	input  logic [VXIN_W-1:0]            voxel_z,
	input  logic                         voxel_solid,
	input  logic signed [COORD_W-1:0]    origin_x,
	input  logic signed [COORD_W-1:0]    origin_y,
	input  logic signed [COORD_W-1:0]    origin_z,
	input  logic signed [COORD_W-1:0]    direction_x,
	input  logic signed [COORD_W-1:0]    direction_y,
	input  logic signed [COORD_W-1:0]    direction_z,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic                         hit,
	output logic signed [OUT_W-1:0]      hit_x,
	output logic signed [OUT_W-1:0]      hit_y,
	output logic signed [OUT_W-1:0]      hit_z,
	output logic signed [OUT_W-1:0]      place_x,
	output logic signed [OUT_W-1:0]      place_y,
	output logic signed [OUT_W-1:0]      place_z
);

	localparam int DEPTH = GRID_EDGE * GRID_EDGE;
	localparam int CW    = $clog2(GRID_EDGE);
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = COORD_W + STEP_W + 1;
	localparam logic [AW-1:0]      EDGE_A   = AW'(GRID_EDGE);
	localparam logic [AW-1:0]      LAST_ROW = AW'(DEPTH - 1);
	localparam logic [VOX_W-2:0]   EDGE_V   = (VOX_W - 1)'(GRID_EDGE);

	logic [STEP_W-1:0] step_q;
	logic [MAXD_W-1:0] maxd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			maxd_q <= MAXD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_STEP_LENGTH:  step_q <= cfg_data[STEP_W-1:0];
				CFG_MAX_DISTANCE: maxd_q <= cfg_data[MAXD_W-1:0];
				default: ;
			endcase
		end
	end

	logic [STEP_W-1:0] step_eff;
	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;

	// ray stepper, one lane per axis
	logic signed [COORD_W-1:0] org_a [3];
	logic signed [COORD_W-1:0] dir_a [3];
	logic signed [PW-1:0]      prod  [3];
	logic signed [POS_W-1:0]   pos_q [3];
	logic signed [POS_W-1:0]   inc_q [3];
	logic signed [VOX_W-1:0]   vox   [3];
	logic [OUT_W-1:0]          prev_q [3];
	logic [2:0]                inb_axis;
	logic [DIST_W-1:0]         dist_q;

	assign org_a = '{origin_x, origin_y, origin_z};
	assign dir_a = '{direction_x, direction_y, direction_z};

	for (genvar i = 0; i < 3; i++) begin : g_lane
		assign prod[i]     = dir_a[i] * $signed({1'b0, step_eff});
		assign vox[i]      = pos_q[i][POS_W-1 -: VOX_W];
		assign inb_axis[i] = !vox[i][VOX_W-1] && (vox[i][VOX_W-2:0] < EDGE_V);

		always_ff @(posedge clk) begin
			if (cmd.accept) begin
				pos_q[i]  <= {{(POS_W - COORD_W - DIR_SHIFT){org_a[i][COORD_W-1]}},
					org_a[i], {DIR_SHIFT{1'b0}}};
				inc_q[i]  <= {{(POS_W - PW){prod[i][PW-1]}}, prod[i]};
				prev_q[i] <= COORD_NONE;
			end else if (cmd.advance) begin
				pos_q[i]  <= pos_q[i] + inc_q[i];
				prev_q[i] <= vox[i][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dist_q <= '0;
		end else if (cmd.advance) begin
			dist_q <= dist_q + DIST_W'(step_eff);
		end
	end

	logic          inb;
	logic [AW-1:0] sample_row;
	assign inb        = &inb_axis;
	assign sample_row = inb ? (AW'(vox[2][CW-1:0]) * EDGE_A + AW'(vox[1][CW-1:0])) : '0;

	// voxel write item
	logic [CW-1:0] wx_q;
	logic [AW-1:0] wrow_q;
	logic          wsolid_q;
	logic          wingrid_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			wx_q      <= CW'(voxel_x);
			wrow_q    <= AW'(voxel_z) * EDGE_A + AW'(voxel_y);
			wsolid_q  <= voxel_solid;
			wingrid_q <= (32'(voxel_x) < GRID_EDGE) && (32'(voxel_y) < GRID_EDGE)
				&& (32'(voxel_z) < GRID_EDGE);
		end
	end

	// clearing pass
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// occupancy rows, one row per (y, z)
	logic [GRID_EDGE-1:0] rdata;
	logic [GRID_EDGE-1:0] row_mod;
	logic [GRID_EDGE-1:0] wdata;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic                 we;

	always_comb begin
		row_mod       = rdata;
		row_mod[wx_q] = wsolid_q;
	end

	assign we    = cmd.clr_step | cmd.wr_write;
	assign waddr = cmd.clr_step ? clr_cnt_q : wrow_q;
	assign wdata = cmd.clr_step ? '0 : row_mod;
	assign raddr = cmd.rd_write ? wrow_q : sample_row;

	vrm_ram #(
		.WIDTH (GRID_EDGE),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result register
	logic             out_valid_q;
	logic             hit_q;
	logic [OUT_W-1:0] res_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_hit || cmd.load_miss) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hit) begin
			hit_q    <= 1'b1;
			res_q[0] <= vox[0][OUT_W-1:0];
			res_q[1] <= vox[1][OUT_W-1:0];
			res_q[2] <= vox[2][OUT_W-1:0];
			res_q[3] <= prev_q[0];
			res_q[4] <= prev_q[1];
			res_q[5] <= prev_q[2];
		end else if (cmd.load_miss) begin
			hit_q <= 1'b0;
			for (int k = 0; k < 6; k++) begin
				res_q[k] <= COORD_NONE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign hit_x     = res_q[0];
	assign hit_y     = res_q[1];
	assign hit_z     = res_q[2];
	assign place_x   = res_q[3];
	assign place_y   = res_q[4];
	assign place_z   = res_q[5];

	assign sts.op_ray     = operation;
	assign sts.clr_last   = (clr_cnt_q == LAST_ROW);
	assign sts.dist_over  = (dist_q > DIST_W'(maxd_q));
	assign sts.solid      = inb && rdata[vox[0][CW-1:0]];
	assign sts.wr_in_grid = wingrid_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule

// File: src/voxel_ray_march_pick_top.sv
// Top level of the voxel ray march pick block.
`timescale 1ns / 1ps

// Keeps a GRID_EDGE^3 occupancy map stored as GRID_EDGE^2 rows of GRID_EDGE bits in one
// RAM. After reset a clearing pass zeroes all GRID_EDGE^2 rows, one row per cycle, with
// in_stall high; configuration writes are taken throughout. A voxel write item is a
// read-modify-write of its row and gives no result. A ray item runs a loop through the
// registered map read, per sample first the row read and then the hit test and the
// position step, until it hits or its distance passes max_distance.
// One item is in work at a time; a finished result waits in the output register while
// the next item is accepted.
module voxel_ray_march_pick_top import vrm_pkg::*; #(
	parameter int GRID_EDGE = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [VXIN_W-1:0]         voxel_x,
	input  logic [VXIN_W-1:0]         voxel_y,
	input  logic [VXIN_W-1:0]         voxel_z,
	input  logic                      voxel_solid,
	input  logic signed [COORD_W-1:0] origin_x,
	input  logic signed [COORD_W-1:0] origin_y,
	input  logic signed [COORD_W-1:0] origin_z,
	input  logic signed [COORD_W-1:0] direction_x,
	input  logic signed [COORD_W-1:0] direction_y,
	input  logic signed [COORD_W-1:0] direction_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit,
	output logic signed [OUT_W-1:0]   hit_x,
	output logic signed [OUT_W-1:0]   hit_y,
	output logic signed [OUT_W-1:0]   hit_z,
	output logic signed [OUT_W-1:0]   place_x,
	output logic signed [OUT_W-1:0]   place_y,
	output logic signed [OUT_W-1:0]   place_z
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	vrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vrm_dp #(
		.GRID_EDGE (GRID_EDGE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.voxel_x     (voxel_x),
		.voxel_y     (voxel_y),
		.voxel_z     (voxel_z),
		.voxel_solid (voxel_solid),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.origin_z    (origin_z),
		.direction_x (direction_x),
		.direction_y (direction_y),
		.direction_z (direction_z),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.hit         (hit),
		.hit_x       (hit_x),
		.hit_y       (hit_y),
		.hit_z       (hit_z),
		.place_x     (place_x),
		.place_y     (place_y),
		.place_z     (place_z)
	);

	a_ray_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation) |=> in_stall)
		else $error("input taken while a ray is marching");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_hit || cmd.load_miss) |-> (!out_valid || !out_stall))
		else $error("result register overwritten while held");

	a_miss_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (hit_x == COORD_NONE && hit_y == COORD_NONE &&
		hit_z == COORD_NONE && place_x == COORD_NONE && place_y == COORD_NONE &&
		place_z == COORD_NONE))
		else $error("miss result carries coordinates");

	a_hit_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (!hit_x[OUT_W-1] && !hit_y[OUT_W-1] && !hit_z[OUT_W-1] &&
		32'(hit_x) < GRID_EDGE && 32'(hit_y) < GRID_EDGE && 32'(hit_z) < GRID_EDGE))
		else $error("hit voxel outside the grid");

endmodule
